// ----- rtl/core/iso_microframe_bandwidth_admit_defines.svh -----
// assertion macros for the property module imfba_props
`ifndef ISO_MICROFRAME_BANDWIDTH_ADMIT_DEFINES_SVH
`define ISO_MICROFRAME_BANDWIDTH_ADMIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define IMFBA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("imfba: same-cycle port check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define IMFBA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("imfba: next-cycle port check failed");

`endif

// ----- rtl/core/imfba_pkg.sv -----
package imfba_pkg;

    // frame list geometry
    localparam int FRAME_SLOTS = 1024;
    localparam int MICROFRAMES = 8;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int MF_IDX_W    = $clog2(MICROFRAMES);

    // field widths
    localparam int SLOT_OUT_W = 10;
    localparam int FRAME_W    = 13;
    localparam int DEV_W      = 7;
    localparam int EP_W       = 4;
    localparam int LEN_W      = 15;
    localparam int MPS_W      = 12;
    localparam int CNT_W      = 13;
    localparam int PKT_W      = 4;
    localparam int MASK_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = LEN_W + 1;
    localparam int ROW_W      = MICROFRAMES * CNT_W;

    // masked frame number reduced to a slot by restoring subtraction
    localparam int REM_W     = SLOT_OUT_W + 1;
    localparam int RED_STEPS =
        $clog2(((1 << SLOT_OUT_W) + FRAME_SLOTS - 1) / FRAME_SLOTS);

    localparam logic [CNT_W-1:0]      COUNTER_MAX     = 13'h1fff;
    localparam logic [CNT_W-1:0]      LIMIT_RESET     = 13'd6000;
    localparam logic [SLOT_OUT_W-1:0] SLOT_MASK_RESET = 10'h3ff;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_LIMIT     = 1'b0,
        REG_SLOT_MASK = 1'b1
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_OVER = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    // classified request handed from front to back
    typedef struct packed {
        logic                                  mode;
        logic                                  bad;
        logic [SLOT_W-1:0]                     slot;
        logic [MASK_W-1:0]                     smask;
        logic [MASK_W-1:0]                     cmask;
        logic [PKT_W-1:0]                      pkts;
        logic [MICROFRAMES-1:0][LEN_W-1:0]     amt;
    } t_job;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

// ----- rtl/core/imfba_ram.sv -----
module imfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/imfba_front.sv -----
module imfba_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic                                i_mode,
    input  logic [imfba_pkg::SLOT_OUT_W-1:0]    i_frame_masked,
    input  logic                                i_split,
    input  logic [imfba_pkg::DEV_W-1:0]         i_device_address,
    input  logic [imfba_pkg::EP_W-1:0]          i_endpoint_number,
    input  logic [imfba_pkg::LEN_W-1:0]         i_transfer_length,
    input  logic [imfba_pkg::MPS_W-1:0]         i_max_packet_size,
    input  logic                                i_full,
    output logic                                o_busy,
    output logic                                o_push,
    output imfba_pkg::t_job                     o_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CUT  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    // mod 3 by summing base-4 digits
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        unique case (t)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [imfba_pkg::SLOT_W-1:0] reduce_slot(
        input logic [imfba_pkg::SLOT_OUT_W-1:0] v
    );
        logic [imfba_pkg::REM_W-1:0] rem;
        rem = {1'b0, v};
        for (int j = imfba_pkg::RED_STEPS - 1; j >= 0; j--) begin
            if (rem >= imfba_pkg::REM_W'(imfba_pkg::FRAME_SLOTS << j)) begin
                rem = rem - imfba_pkg::REM_W'(imfba_pkg::FRAME_SLOTS << j);
            end
        end
        return rem[imfba_pkg::SLOT_W-1:0];
    endfunction

    t_fstate                              r_state, n_state;
    logic [imfba_pkg::SLOT_OUT_W-1:0]     r_frame;
    logic                                 r_split;
    logic [imfba_pkg::DEV_W-1:0]          r_dev;
    logic [imfba_pkg::EP_W-1:0]           r_ep;
    logic [imfba_pkg::LEN_W-1:0]          r_len;
    logic [imfba_pkg::MPS_W-1:0]          r_mps;
    logic [imfba_pkg::LEN_W-1:0]          r_left, n_left;
    logic [imfba_pkg::MF_IDX_W-1:0]       r_k, n_k;
    imfba_pkg::t_job                      r_job, n_job;

    logic [imfba_pkg::LEN_W-1:0]          pkt;
    logic [imfba_pkg::LEN_W-1:0]          left_after;
    logic [1:0]                           start_mf;
    logic [imfba_pkg::MASK_W-1:0]         smask;
    logic [imfba_pkg::MASK_W-1:0]         cmask;

    assign pkt        = (r_left > imfba_pkg::LEN_W'(r_mps)) ? imfba_pkg::LEN_W'(r_mps) : r_left;
    assign left_after = r_left - pkt;
    assign start_mf   = mod3(8'(r_dev) + 8'(r_ep));
    assign smask      = imfba_pkg::MASK_W'(1) << start_mf;
    assign cmask      = imfba_pkg::MASK_W'(8'b0001_1100) << start_mf;

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_k     = r_k;
        n_job   = r_job;
        unique case (r_state)
            F_IDLE: begin
                if (i_take) begin
                    n_job      = '0;
                    n_job.mode = i_mode;
                    n_left     = i_transfer_length;
                    n_k        = '0;
                    n_state    = F_CUT;
                end
            end
            F_CUT: begin
                n_job.slot = reduce_slot(r_frame);
                priority if (r_len == '0 || r_mps == '0) begin
                    n_job.bad = 1'b1;
                    n_state   = F_PUSH;
                end else if (r_split) begin
                    n_job.smask = smask;
                    n_job.cmask = cmask;
                    n_job.pkts  = imfba_pkg::PKT_W'(1);
                    for (int i = 0; i < imfba_pkg::MICROFRAMES; i++) begin
                        n_job.amt[i] = (smask[i] | cmask[i]) ? r_len : '0;
                    end
                    n_state = F_PUSH;
                end else begin
                    // one high-speed packet per cycle
                    n_job.amt[r_k] = pkt;
                    n_job.pkts     = r_job.pkts + imfba_pkg::PKT_W'(1);
                    n_left         = left_after;
                    if (left_after == '0 ||
                        r_k == imfba_pkg::MF_IDX_W'(imfba_pkg::MICROFRAMES - 1)) begin
                        n_state = F_PUSH;
                    end else begin
                        n_k = r_k + imfba_pkg::MF_IDX_W'(1);
                    end
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_k    <= n_k;
        r_job  <= n_job;
        if (r_state == F_IDLE && i_take) begin
            r_frame <= i_frame_masked;
            r_split <= i_split;
            r_dev   <= i_device_address;
            r_ep    <= i_endpoint_number;
            r_len   <= i_transfer_length;
            r_mps   <= i_max_packet_size;
        end
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = r_job;

endmodule

// ----- rtl/core/imfba_queue.sv -----
module imfba_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  imfba_pkg::t_job i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output imfba_pkg::t_job o_data
);

    function automatic logic [imfba_pkg::Q_PTR_W-1:0] bump(
        input logic [imfba_pkg::Q_PTR_W-1:0] p
    );
        return (p == imfba_pkg::Q_PTR_W'(imfba_pkg::Q_DEPTH - 1)) ?
            '0 : p + imfba_pkg::Q_PTR_W'(1);
    endfunction

    imfba_pkg::t_job                    r_data [imfba_pkg::Q_DEPTH];
    logic [imfba_pkg::Q_PTR_W-1:0]      r_wptr, r_rptr;
    logic [imfba_pkg::Q_CNT_W-1:0]      r_count, n_count;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + imfba_pkg::Q_CNT_W'(1);
            2'b01:   n_count = r_count - imfba_pkg::Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == imfba_pkg::Q_CNT_W'(imfba_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rptr];

endmodule

// ----- rtl/core/imfba_back.sv -----
module imfba_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [imfba_pkg::CNT_W-1:0]       i_limit,
    input  logic                              i_valid,
    input  imfba_pkg::t_job                   i_job,
    output logic                              o_pop,
    output logic                              o_clearing,
    output logic                              o_valid,
    output logic                              o_accepted,
    output logic [imfba_pkg::STATUS_W-1:0]    o_status,
    output logic [imfba_pkg::SLOT_W-1:0]      o_slot,
    output logic [imfba_pkg::MASK_W-1:0]      o_smask,
    output logic [imfba_pkg::MASK_W-1:0]      o_cmask,
    output logic [imfba_pkg::PKT_W-1:0]       o_pkts
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_CALC  = 3'b100
    } t_bstate;

    t_bstate                                          r_state, n_state;
    logic [imfba_pkg::SLOT_W-1:0]                     r_clr;
    imfba_pkg::t_job                                  r_job;

    logic                                             r_valid, n_valid;
    logic                                             r_accepted, n_accepted;
    imfba_pkg::t_status                               r_status, n_status;
    logic [imfba_pkg::SLOT_W-1:0]                     r_slot, n_slot;
    logic [imfba_pkg::MASK_W-1:0]                     r_smask, n_smask;
    logic [imfba_pkg::MASK_W-1:0]                     r_cmask, n_cmask;
    logic [imfba_pkg::PKT_W-1:0]                      r_pkts, n_pkts;

    logic                                             ram_we;
    logic [imfba_pkg::SLOT_W-1:0]                     ram_waddr;
    logic [imfba_pkg::ROW_W-1:0]                      ram_wdata;
    logic                                             ram_re;
    logic [imfba_pkg::ROW_W-1:0]                      ram_rdata;

    logic [imfba_pkg::MICROFRAMES-1:0][imfba_pkg::CNT_W-1:0] rd_row, add_row, sub_row;
    logic [imfba_pkg::MICROFRAMES-1:0][imfba_pkg::SUM_W-1:0] sum;
    logic [imfba_pkg::MICROFRAMES-1:0]                        over;
    logic                                                      fits;

    imfba_ram #(
        .WIDTH (imfba_pkg::ROW_W),
        .DEPTH (imfba_pkg::FRAME_SLOTS)
    ) u_usage (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_job.slot),
        .o_rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    // all eight counters of the row side by side
    always_comb begin
        for (int i = 0; i < imfba_pkg::MICROFRAMES; i++) begin
            sum[i]  = imfba_pkg::SUM_W'(rd_row[i]) + imfba_pkg::SUM_W'(r_job.amt[i]);
            over[i] = (r_job.amt[i] != '0) && (sum[i] > imfba_pkg::SUM_W'(i_limit));
            add_row[i] = (sum[i] > imfba_pkg::SUM_W'(imfba_pkg::COUNTER_MAX)) ?
                imfba_pkg::COUNTER_MAX : sum[i][imfba_pkg::CNT_W-1:0];
            sub_row[i] = (imfba_pkg::LEN_W'(rd_row[i]) > r_job.amt[i]) ?
                imfba_pkg::CNT_W'(imfba_pkg::LEN_W'(rd_row[i]) - r_job.amt[i]) : '0;
        end
    end

    assign fits   = ~|over;
    assign o_pop  = (r_state == B_IDLE) && i_valid;
    assign ram_re = o_pop && !i_job.bad;

    always_comb begin
        n_state    = r_state;
        ram_we     = 1'b0;
        ram_waddr  = r_job.slot;
        ram_wdata  = '0;
        n_valid    = 1'b0;
        n_accepted = r_accepted;
        n_status   = r_status;
        n_slot     = r_slot;
        n_smask    = r_smask;
        n_cmask    = r_cmask;
        n_pkts     = r_pkts;
        unique case (r_state)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == imfba_pkg::SLOT_W'(imfba_pkg::FRAME_SLOTS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (o_pop) begin
                    if (i_job.bad) begin
                        n_valid    = 1'b1;
                        n_accepted = 1'b0;
                        n_status   = imfba_pkg::STATUS_BAD;
                        n_slot     = i_job.slot;
                        n_smask    = i_job.smask;
                        n_cmask    = i_job.cmask;
                        n_pkts     = i_job.pkts;
                    end else begin
                        n_state = B_CALC;
                    end
                end
            end
            B_CALC: begin
                ram_we     = r_job.mode || fits;
                ram_wdata  = r_job.mode ? sub_row : add_row;
                n_valid    = 1'b1;
                n_accepted = r_job.mode || fits;
                n_status   = (r_job.mode || fits) ? imfba_pkg::STATUS_OK : imfba_pkg::STATUS_OVER;
                n_slot     = r_job.slot;
                n_smask    = r_job.smask;
                n_cmask    = r_job.cmask;
                n_pkts     = r_job.pkts;
                n_state    = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + imfba_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= n_accepted;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_smask    <= n_smask;
        r_cmask    <= n_cmask;
        r_pkts     <= n_pkts;
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_valid    = r_valid;
    assign o_accepted = r_accepted;
    assign o_status   = r_status;
    assign o_slot     = r_slot;
    assign o_smask    = r_smask;
    assign o_cmask    = r_cmask;
    assign o_pkts     = r_pkts;

endmodule

// ----- rtl/core/iso_microframe_bandwidth_admit.sv -----
// periodic bandwidth admission: one 13-bit byte counter per microframe of every frame slot
// request channel: a transfer is taken at a clock edge with start high and busy low;
//   mode 0 admits and reserves, mode 1 releases a reservation
// result channel: o_valid marks a single cycle carrying accepted, status, slot index,
//   split masks and packet count; the receiver cannot hold it off, one result per request
// config: apb-style port, microframe_byte_limit at 0x0, slot_mask at 0x4, pready tied high
// path: a taken request passes the front end states IDLE, CUT and PUSH, the queue and
//   the back end states IDLE (memory read) and CALC (memory write, registered result);
//   a bad-parameter request skips CALC, a full queue holds the front end in PUSH, and the
//   front end takes a new request once it has pushed the last; it cuts one high-speed
//   packet per cycle, the back end a read-modify-write of the slot row in the usage memory
// a two-entry queue between the front end and the back end decouples them
// reset: limit 6000, slot mask 0x3ff; the usage memory is then swept to zero, one slot
//   row per cycle over the 1024 slots, busy held high; config writes are taken meanwhile
// no stall on the result side: results always drain at the back end's own pace
module iso_microframe_bandwidth_admit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [imfba_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [imfba_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [imfba_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready,
    // request channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_mode,
    input  logic [imfba_pkg::FRAME_W-1:0]         i_frame_number,
    input  logic                                  i_split_transfer,
    input  logic [imfba_pkg::DEV_W-1:0]           i_device_address,
    input  logic [imfba_pkg::EP_W-1:0]            i_endpoint_number,
    input  logic [imfba_pkg::LEN_W-1:0]           i_transfer_length,
    input  logic [imfba_pkg::MPS_W-1:0]           i_max_packet_size,
    // result channel
    output logic                                  o_valid,
    output logic                                  o_accepted,
    output logic [imfba_pkg::STATUS_W-1:0]        o_status,
    output logic [imfba_pkg::SLOT_OUT_W-1:0]      o_slot_index,
    output logic [imfba_pkg::MASK_W-1:0]          o_start_mask,
    output logic [imfba_pkg::MASK_W-1:0]          o_complete_mask,
    output logic [imfba_pkg::PKT_W-1:0]           o_packet_count
);

    // configuration registers
    logic [imfba_pkg::CNT_W-1:0]          r_limit;
    logic [imfba_pkg::SLOT_OUT_W-1:0]     r_slot_mask;
    imfba_pkg::t_reg_idx                  reg_idx;
    logic                                 cfg_write;

    // front to queue to back
    logic                                 take;
    logic                                 front_busy;
    logic                                 clearing;
    logic                                 push;
    logic                                 q_full;
    logic                                 q_valid;
    logic                                 pop;
    imfba_pkg::t_job                      front_job;
    imfba_pkg::t_job                      back_job;
    logic [imfba_pkg::SLOT_W-1:0]         slot;

    // register decode, low address bits ignored
    assign reg_idx   = imfba_pkg::t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= imfba_pkg::LIMIT_RESET;
            r_slot_mask <= imfba_pkg::SLOT_MASK_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                imfba_pkg::REG_LIMIT:     r_limit     <= pwdata[imfba_pkg::CNT_W-1:0];
                imfba_pkg::REG_SLOT_MASK: r_slot_mask <= pwdata[imfba_pkg::SLOT_OUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            imfba_pkg::REG_LIMIT:     prdata = imfba_pkg::APB_DATA_W'(r_limit);
            imfba_pkg::REG_SLOT_MASK: prdata = imfba_pkg::APB_DATA_W'(r_slot_mask);
            default:                  prdata = '0;
        endcase
    end

    // a transfer is taken only once the front end is free and the sweep is done
    assign busy = front_busy || clearing;
    assign take = start && !busy;

    imfba_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (take),
        .i_mode            (i_mode),
        .i_frame_masked    (i_frame_number[imfba_pkg::SLOT_OUT_W-1:0] & r_slot_mask),
        .i_split           (i_split_transfer),
        .i_device_address  (i_device_address),
        .i_endpoint_number (i_endpoint_number),
        .i_transfer_length (i_transfer_length),
        .i_max_packet_size (i_max_packet_size),
        .i_full            (q_full),
        .o_busy            (front_busy),
        .o_push            (push),
        .o_job             (front_job)
    );

    imfba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (back_job)
    );

    imfba_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_limit),
        .i_valid    (q_valid),
        .i_job      (back_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_accepted (o_accepted),
        .o_status   (o_status),
        .o_slot     (slot),
        .o_smask    (o_start_mask),
        .o_cmask    (o_complete_mask),
        .o_pkts     (o_packet_count)
    );

    // slot index cast to the port width
    assign o_slot_index = imfba_pkg::SLOT_OUT_W'(slot);

endmodule

// ----- rtl/core/imfba_checker.sv -----
`include "iso_microframe_bandwidth_admit_defines.svh"

module imfba_props (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  o_valid,
    input logic                                  o_accepted,
    input logic [imfba_pkg::STATUS_W-1:0]        o_status,
    input logic [imfba_pkg::MASK_W-1:0]          o_start_mask,
    input logic [imfba_pkg::MASK_W-1:0]          o_complete_mask,
    input logic [imfba_pkg::PKT_W-1:0]           o_packet_count
);

    // accepted goes with an ok status and nothing else
    `IMFBA_ASSERT_IMPL(a_accept_status, o_valid, o_accepted == (o_status == imfba_pkg::STATUS_OK))

    // bad parameters report empty masks and no packets
    `IMFBA_ASSERT_IMPL(a_bad_empty, o_valid && o_status == imfba_pkg::STATUS_BAD, o_start_mask == '0 && o_complete_mask == '0 && o_packet_count == '0)

    // any checked request uses one to eight microframes
    `IMFBA_ASSERT_IMPL(a_pkt_range, o_valid && o_status != imfba_pkg::STATUS_BAD, o_packet_count != '0 && o_packet_count <= imfba_pkg::PKT_W'(imfba_pkg::MICROFRAMES))

    // a taken transfer occupies the front end
    `IMFBA_ASSERT_NEXT(a_busy_after_take, start && !busy, busy)

    // the usage sweep keeps requests out straight after reset
    `IMFBA_ASSERT_IMPL(a_busy_after_reset, !$past(i_rst_n), busy)

endmodule

bind iso_microframe_bandwidth_admit imfba_props u_imfba_props (.*);

// ----- tb/imfba_checker.sv -----
// watches the request, result and configuration channels of the bandwidth admission block,
// keeps its own copy of the per-microframe byte counters and compares every result
module imfba_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [imfba_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [imfba_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic                                  pready,
    // request channel
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  i_mode,
    input  logic [imfba_pkg::FRAME_W-1:0]         i_frame_number,
    input  logic                                  i_split_transfer,
    input  logic [imfba_pkg::DEV_W-1:0]           i_device_address,
    input  logic [imfba_pkg::EP_W-1:0]            i_endpoint_number,
    input  logic [imfba_pkg::LEN_W-1:0]           i_transfer_length,
    input  logic [imfba_pkg::MPS_W-1:0]           i_max_packet_size,
    // result channel
    input  logic                                  i_res_valid,
    input  logic                                  i_res_accepted,
    input  logic [imfba_pkg::STATUS_W-1:0]        i_res_status,
    input  logic [imfba_pkg::SLOT_OUT_W-1:0]      i_res_slot_index,
    input  logic [imfba_pkg::MASK_W-1:0]          i_res_start_mask,
    input  logic [imfba_pkg::MASK_W-1:0]          i_res_complete_mask,
    input  logic [imfba_pkg::PKT_W-1:0]           i_res_packet_count,
    // to the top
    output int                                    o_fail_count,
    output int                                    o_outstanding,
    output int                                    o_results_checked,
    output int                                    o_over_budget_seen
);

    import imfba_pkg::*;

    typedef struct packed {
        logic                  accepted;
        t_status               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [MASK_W-1:0]     smask;
        logic [MASK_W-1:0]     cmask;
        logic [PKT_W-1:0]      pkts;
    } admission_t;

    logic [CNT_W-1:0]      mf_usage [FRAME_SLOTS][MICROFRAMES];
    logic [CNT_W-1:0]      byte_limit;
    logic [SLOT_OUT_W-1:0] slot_sel_mask;
    admission_t            expected_admissions [$];

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    // works out the outcome of one request and books it into the counters
    function automatic admission_t schedule_bandwidth(
        input logic               freeing,
        input logic [FRAME_W-1:0] frame,
        input logic               split,
        input logic [DEV_W-1:0]   dev,
        input logic [EP_W-1:0]    ep,
        input logic [LEN_W-1:0]   len,
        input logic [MPS_W-1:0]   mps
    );
        admission_t res;
        int         amount [MICROFRAMES];
        int         slot;
        int         first_mf;
        int         left;
        int         share;
        int         sum;
        int         pkts;
        logic       fits;
        res  = '0;
        slot = int'(frame & FRAME_W'(slot_sel_mask)) % FRAME_SLOTS;
        res.slot = SLOT_OUT_W'(slot);
        for (int i = 0; i < MICROFRAMES; i++) amount[i] = 0;
        if (len == '0 || mps == '0) begin
            res.status = STATUS_BAD;
            return res;
        end
        if (split) begin
            // one start-split and three complete-splits, each carrying the whole length
            first_mf  = (int'(dev) + int'(ep)) % 3;
            res.smask = MASK_W'(1) << first_mf;
            res.cmask = MASK_W'(7) << (first_mf + 2);
            res.pkts  = PKT_W'(1);
            for (int i = 0; i < MICROFRAMES; i++) begin
                if (res.smask[i] || res.cmask[i]) amount[i] = int'(len);
            end
        end else begin
            pkts = (int'(len) + int'(mps) - 1) / int'(mps);
            if (pkts > MICROFRAMES) pkts = MICROFRAMES;
            res.pkts = PKT_W'(pkts);
            left = int'(len);
            for (int i = 0; i < pkts; i++) begin
                share     = (left > int'(mps)) ? int'(mps) : left;
                amount[i] = share;
                left     -= share;
            end
        end
        if (!freeing) begin
            fits = 1'b1;
            for (int i = 0; i < MICROFRAMES; i++) begin
                if (amount[i] != 0 && int'(mf_usage[slot][i]) + amount[i] > int'(byte_limit))
                    fits = 1'b0;
            end
            if (fits) begin
                for (int i = 0; i < MICROFRAMES; i++) begin
                    sum = int'(mf_usage[slot][i]) + amount[i];
                    if (sum > int'(COUNTER_MAX)) sum = int'(COUNTER_MAX);
                    mf_usage[slot][i] = CNT_W'(sum);
                end
                res.accepted = 1'b1;
            end else begin
                res.status = STATUS_OVER;
            end
        end else begin
            for (int i = 0; i < MICROFRAMES; i++) begin
                mf_usage[slot][i] = (int'(mf_usage[slot][i]) > amount[i]) ?
                                    CNT_W'(int'(mf_usage[slot][i]) - amount[i]) : '0;
            end
            res.accepted = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        admission_t want;
        if (!i_rst_n) begin
            for (int s = 0; s < FRAME_SLOTS; s++)
                for (int m = 0; m < MICROFRAMES; m++) mf_usage[s][m] = '0;
            byte_limit    = LIMIT_RESET;
            slot_sel_mask = SLOT_MASK_RESET;
            expected_admissions.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (t_reg_idx'(paddr[2]))
                    REG_LIMIT:     byte_limit    = pwdata[CNT_W-1:0];
                    REG_SLOT_MASK: slot_sel_mask = pwdata[SLOT_OUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid) begin
                if (expected_admissions.size() == 0) begin
                    note_mismatch("result with no request outstanding");
                end else begin
                    want = expected_admissions.pop_front();
                    o_results_checked++;
                    if (want.status == STATUS_OVER) o_over_budget_seen++;
                    if (i_res_accepted !== want.accepted)
                        note_mismatch($sformatf("accepted %0b, expected %0b (slot %0d)",
                                                i_res_accepted, want.accepted, want.slot));
                    if (i_res_status !== want.status)
                        note_mismatch($sformatf("status %0d, expected %0d (slot %0d)",
                                                i_res_status, want.status, want.slot));
                    if (i_res_slot_index !== want.slot)
                        note_mismatch($sformatf("slot %0d, expected %0d",
                                                i_res_slot_index, want.slot));
                    if (i_res_start_mask !== want.smask)
                        note_mismatch($sformatf("start mask %02h, expected %02h (slot %0d)",
                                                i_res_start_mask, want.smask, want.slot));
                    if (i_res_complete_mask !== want.cmask)
                        note_mismatch($sformatf("complete mask %02h, expected %02h (slot %0d)",
                                                i_res_complete_mask, want.cmask, want.slot));
                    if (i_res_packet_count !== want.pkts)
                        note_mismatch($sformatf("packet count %0d, expected %0d (slot %0d)",
                                                i_res_packet_count, want.pkts, want.slot));
                end
            end
            if (start && !busy) begin
                expected_admissions.push_back(schedule_bandwidth(
                    i_mode, i_frame_number, i_split_transfer, i_device_address,
                    i_endpoint_number, i_transfer_length, i_max_packet_size));
            end
        end
        o_outstanding = expected_admissions.size();
    end

endmodule

// ----- tb/iso_microframe_bandwidth_admit_tb.sv -----
// top of the bandwidth admission testbench: clock, reset, register writes, request
// stimulus and the verdict; all prediction and comparison lives in the checker
module iso_microframe_bandwidth_admit_tb;

    import imfba_pkg::*;

    // request kinds on i_mode
    localparam logic MODE_ADMIT   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // cycles with no request, result or register write before the run is declared hung;
    // covers the clearing sweep after reset many times over
    localparam int STALL_LIMIT  = 6000;
    // quiet cycles after the last result, to catch a stray strobe
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 200;
    localparam int BOOKED_DEPTH = 64;

    typedef struct packed {
        logic               mode;
        logic [FRAME_W-1:0] frame;
        logic               split;
        logic [DEV_W-1:0]   dev;
        logic [EP_W-1:0]    ep;
        logic [LEN_W-1:0]   len;
        logic [MPS_W-1:0]   mps;
    } request_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic                  i_mode;
    logic [FRAME_W-1:0]    i_frame_number;
    logic                  i_split_transfer;
    logic [DEV_W-1:0]      i_device_address;
    logic [EP_W-1:0]       i_endpoint_number;
    logic [LEN_W-1:0]      i_transfer_length;
    logic [MPS_W-1:0]      i_max_packet_size;
    logic                  o_valid;
    logic                  o_accepted;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic [MASK_W-1:0]     o_start_mask;
    logic [MASK_W-1:0]     o_complete_mask;
    logic [PKT_W-1:0]      o_packet_count;

    int fail_count;
    int pending_results;
    int results_checked;
    int over_budget_seen;

    // stimulus bookkeeping
    int                    stall_cycles = 0;
    int                    burst_left   = 0;
    int                    n_admit      = 0;
    int                    n_free       = 0;
    int                    n_split      = 0;
    int                    n_bad        = 0;
    request_t              booked_admits [$];
    logic [SLOT_OUT_W-1:0] hot_low [4];
    int unsigned           phase_limit [PHASES] = '{6000, 8191, 1500, 0, 8191, 0, 0};
    int unsigned           phase_mask  [PHASES] = '{1023, 1023, 7, 1023, 0, 0, 0};

    always #5 i_clk = ~i_clk;

    iso_microframe_bandwidth_admit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_frame_number    (i_frame_number),
        .i_split_transfer  (i_split_transfer),
        .i_device_address  (i_device_address),
        .i_endpoint_number (i_endpoint_number),
        .i_transfer_length (i_transfer_length),
        .i_max_packet_size (i_max_packet_size),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_status          (o_status),
        .o_slot_index      (o_slot_index),
        .o_start_mask      (o_start_mask),
        .o_complete_mask   (o_complete_mask),
        .o_packet_count    (o_packet_count)
    );

    imfba_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_frame_number      (i_frame_number),
        .i_split_transfer    (i_split_transfer),
        .i_device_address    (i_device_address),
        .i_endpoint_number   (i_endpoint_number),
        .i_transfer_length   (i_transfer_length),
        .i_max_packet_size   (i_max_packet_size),
        .i_res_valid         (o_valid),
        .i_res_accepted      (o_accepted),
        .i_res_status        (o_status),
        .i_res_slot_index    (o_slot_index),
        .i_res_start_mask    (o_start_mask),
        .i_res_complete_mask (o_complete_mask),
        .i_res_packet_count  (o_packet_count),
        .o_fail_count        (fail_count),
        .o_outstanding       (pending_results),
        .o_results_checked   (results_checked),
        .o_over_budget_seen  (over_budget_seen)
    );

    // watchdog: any request, result or register write counts as progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable && pwrite)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic request_t req(input logic mode, input int frame, input logic split,
                                     input int dev, input int ep, input int len,
                                     input int mps);
        request_t rq;
        rq.mode  = mode;
        rq.frame = FRAME_W'(frame);
        rq.split = split;
        rq.dev   = DEV_W'(dev);
        rq.ep    = EP_W'(ep);
        rq.len   = LEN_W'(len);
        rq.mps   = MPS_W'(mps);
        return rq;
    endfunction

    // idle cycles before the next request: mostly none, now and then a long gap,
    // and occasional bursts where the sender never lets go of start
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            burst_left = $urandom_range(80, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // mostly admits aimed at a few busy slots and releases of earlier admits, so the
    // counters fill up and drain; the rest is malformed or entirely random
    function automatic request_t next_random_request();
        request_t rq;
        int       r;
        int       idx;
        r = $urandom_range(99);
        rq = req(MODE_ADMIT, $urandom, 1'($urandom_range(1)), $urandom, $urandom,
                 $urandom_range(24576), $urandom_range(3072));
        if (r < 10) begin
            rq.mode = 1'($urandom_range(1));
        end else if (r < 16) begin
            rq.mode = 1'($urandom_range(1));
            if ($urandom_range(1)) rq.len = '0;
            else rq.mps = '0;
        end else if (r < 42 && booked_admits.size() != 0) begin
            idx = $urandom_range(booked_admits.size() - 1);
            rq = booked_admits[idx];
            booked_admits.delete(idx);
            rq.mode = MODE_RELEASE;
        end else begin
            if ($urandom_range(9) < 7)
                rq.frame = {FRAME_W'($urandom_range(7)) << SLOT_OUT_W}
                           | FRAME_W'(hot_low[$urandom_range(3)]);
            rq.split = ($urandom_range(9) < 4);
            if (rq.split) begin
                rq.len = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(1500, 1))
                                                   : LEN_W'($urandom_range(24576, 1));
                rq.mps = MPS_W'($urandom_range(3072, 1));
            end else begin
                rq.mps = ($urandom_range(9) < 3) ? MPS_W'($urandom_range(64, 1))
                                                 : MPS_W'($urandom_range(3072, 1));
                rq.len = ($urandom_range(9) < 8) ? LEN_W'($urandom_range(6000, 1))
                                                 : LEN_W'($urandom_range(24576, 1));
            end
            if (booked_admits.size() == BOOKED_DEPTH) void'(booked_admits.pop_front());
            booked_admits.push_back(rq);
        end
        return rq;
    endfunction

    // present one request and hold it until the block takes it
    task automatic send_request(input request_t rq);
        @(negedge i_clk);
        start             <= 1'b1;
        i_mode            <= rq.mode;
        i_frame_number    <= rq.frame;
        i_split_transfer  <= rq.split;
        i_device_address  <= rq.dev;
        i_endpoint_number <= rq.ep;
        i_transfer_length <= rq.len;
        i_max_packet_size <= rq.mps;
        do @(posedge i_clk); while (busy);
        if (rq.mode == MODE_ADMIT) n_admit++;
        else n_free++;
        if (rq.split) n_split++;
        if (rq.len == '0 || rq.mps == '0) n_bad++;
    endtask

    // drop start for the given number of cycles; zero keeps it high for back-to-back
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // setup then access phase; pready is tied high so the write lands on the access edge.
    // bits above the register width carry junk, the block has to ignore them
    task automatic write_register(input t_reg_idx idx, input logic [CNT_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        data             = $urandom;
        data[CNT_W-1:0]  = value;
        if (idx == REG_SLOT_MASK)
            data[CNT_W-1:SLOT_OUT_W] = (CNT_W-SLOT_OUT_W)'($urandom);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender pause: nothing new goes in until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    initial begin
        // every input known from time zero, reset held low at the start
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        start             = 1'b0;
        i_mode            = MODE_ADMIT;
        i_frame_number    = '0;
        i_split_transfer  = 1'b0;
        i_device_address  = '0;
        i_endpoint_number = '0;
        i_transfer_length = '0;
        i_max_packet_size = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the block takes register writes during its clearing sweep
        write_register(REG_LIMIT, 13'd6000);
        write_register(REG_SLOT_MASK, 13'd1023);

        // directed: field extremes, packet splitting, all three split start positions,
        // budget edges, malformed requests and releases below zero
        send_request(req(MODE_ADMIT, 0, 0, 0, 0, 1, 1));
        send_request(req(MODE_ADMIT, 8191, 0, 127, 15, 24576, 3072));
        send_request(req(MODE_ADMIT, 8191, 0, 0, 0, 24576, 3072));      // over budget
        send_request(req(MODE_ADMIT, 1, 0, 0, 0, 24576, 1));            // eight packets, rest dropped
        hold_off(pick_gap());
        send_request(req(MODE_ADMIT, 2, 0, 0, 0, 3000, 3072));          // one short packet
        send_request(req(MODE_ADMIT, 2, 0, 0, 0, 6145, 2048));          // one-byte last packet
        send_request(req(MODE_ADMIT, 3, 1, 0, 0, 1, 1));                // split, start at 0
        send_request(req(MODE_ADMIT, 3, 1, 127, 15, 700, 3072));        // split, start at 1
        hold_off(pick_gap());
        send_request(req(MODE_ADMIT, 3, 1, 125, 15, 500, 12));          // split, start at 2
        send_request(req(MODE_ADMIT, 4, 1, 0, 0, 6000, 5));             // exactly at the limit
        send_request(req(MODE_ADMIT, 4, 1, 0, 0, 1, 5));                // one byte over
        send_request(req(MODE_ADMIT, 5, 1, 3, 3, 24576, 3072));         // split far over budget
        send_request(req(MODE_ADMIT, 7, 0, 0, 0, 0, 100));              // zero length
        send_request(req(MODE_ADMIT, 7, 1, 0, 0, 100, 0));              // zero packet size
        send_request(req(MODE_RELEASE, 7, 1, 0, 0, 0, 100));
        send_request(req(MODE_RELEASE, 7, 0, 0, 0, 100, 0));
        hold_off(pick_gap());
        send_request(req(MODE_RELEASE, 8191, 0, 0, 0, 24576, 3072));
        send_request(req(MODE_RELEASE, 8191, 0, 0, 0, 24576, 3072));    // floors at zero
        send_request(req(MODE_RELEASE, 6, 1, 5, 9, 300, 1));            // never admitted
        send_request(req(MODE_RELEASE, 4, 1, 0, 0, 6000, 5));
        send_request(req(MODE_ADMIT, 4, 1, 0, 0, 1, 5));                // fits again
        send_request(req(MODE_ADMIT, 13'h1c05, 0, 0, 0, 100, 64));      // high frame bits masked

        // random phases over a spread of limits and slot masks, the extremes among them
        phase_limit[5] = $urandom_range(8191);
        phase_mask[5]  = $urandom_range(1023);
        phase_limit[6] = $urandom_range(3000, 500);
        phase_mask[6]  = $urandom_range(1023);
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_register(REG_LIMIT, CNT_W'(phase_limit[p]));
            write_register(REG_SLOT_MASK, CNT_W'(phase_mask[p]));
            for (int h = 0; h < 4; h++) hot_low[h] = SLOT_OUT_W'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                hold_off(pick_gap());
                send_request(next_random_request());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("requests: %0d admit, %0d release, %0d split, %0d malformed",
                 n_admit, n_free, n_split, n_bad);
        $display("results checked: %0d, over budget: %0d, over %0d limit/mask settings",
                 results_checked, over_budget_seen, PHASES + 1);
        if (fail_count == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/imfba_pkg.sv
rtl/core/imfba_ram.sv
rtl/core/imfba_front.sv
rtl/core/imfba_queue.sv
rtl/core/imfba_back.sv
rtl/core/iso_microframe_bandwidth_admit.sv
rtl/core/imfba_checker.sv
tb/imfba_checker.sv
tb/iso_microframe_bandwidth_admit_tb.sv
